// ===== sv/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg: shared types and constants of the sensor frame parser
// Register indexes, reset values, field widths and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

    localparam int PARAM_DEPTH_DEF = 64;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 6;
    localparam int SUM_W   = 16;
    localparam int OUT_W   = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [SUM_W-1:0] SUM_MOD = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE    = 2'd2;

    localparam logic [BYTE_W-1:0] HEADER_RST  = 8'd170;
    localparam logic [BYTE_W-1:0] VERSION_RST = 8'd1;
    localparam logic [BYTE_W-1:0] TYPE_RST    = 8'd97;

    // controller to datapath
    typedef struct packed {
        logic sum_clr;
        logic sum_add;
        logic ld_len_hi;
        logic ld_len_lo;
        logic ld_cmd;
        logic ld_plen_hi;
        logic ld_plen_lo;
        logic wr_param;
        logic ld_sum_hi;
        logic emit_clr;
        logic emit_rd;
        logic emit_ld;
    } sfp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hdr_ok;
        logic ver_ok;
        logic type_ok;
        logic plen_ok;
        logic params_done;
        logic sum_ok;
        logic emit_last;
        logic out_busy;
    } sfp_sts_t;

endpackage

`default_nettype wire

// ===== sv/sfp_ram.sv =====
// ----------------------------------------------------------------------------
// sfp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/sfp_datapath.sv =====
// ----------------------------------------------------------------------------
// sfp_datapath: frame fields, checksum and parameter buffer
// Holds the configuration registers, the running sum, the captured fields,
// the parameter RAM and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_datapath #(
    parameter int PARAM_DEPTH = sfp_pkg::PARAM_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sfp_pkg::sfp_cmd_t             cmd,
    output sfp_pkg::sfp_sts_t                  sts,
    input  wire logic [sfp_pkg::BYTE_W-1:0]    in_byte,
    input  wire logic                          cfg_fire,
    input  wire logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sfp_pkg::BYTE_W-1:0]    cfg_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sfp_pkg::OUT_W-1:0]          m_data,
    output logic                               m_last
);

    import sfp_pkg::*;

    localparam int AW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(PARAM_DEPTH);

    logic [BYTE_W-1:0]  header_reg, version_reg, type_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W:0]     sum_wide;
    logic [COUNT_W-1:0] taken_reg, taken_inc;
    logic [COUNT_W-1:0] expected_reg;
    logic [BYTE_W-1:0]  plen_hi_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [BYTE_W-1:0]  command_reg;
    logic [BYTE_W-1:0]  sum_hi_reg;
    logic [COUNT_W-1:0] emit_reg, emit_inc;
    logic [BYTE_W-1:0]  ram_rd_data;

    logic               out_valid_reg;
    logic               out_last_reg;
    logic [BYTE_W-1:0]  out_cmd_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [BYTE_W-1:0]  out_byte_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= HEADER_RST;
            version_reg <= VERSION_RST;
            type_reg    <= TYPE_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_HEADER:  header_reg  <= cfg_data;
                REG_VERSION: version_reg <= cfg_data;
                REG_TYPE:    type_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    // running sum, reduced modulo 0xffff after each byte
    assign sum_wide = {1'b0, sum_reg} + {{(SUM_W + 1 - BYTE_W){1'b0}}, in_byte};
    always_comb
    begin
        if (sum_wide >= {1'b0, SUM_MOD})
        begin
            sum_next = SUM_W'(sum_wide - {1'b0, SUM_MOD});
        end
        else
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    assign taken_inc = taken_reg + COUNT_W'(1);
    assign emit_inc  = emit_reg + COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            taken_reg    <= '0;
            expected_reg <= '0;
            plen_hi_reg  <= '0;
            length_reg   <= '0;
            command_reg  <= '0;
            sum_hi_reg   <= '0;
            emit_reg     <= '0;
        end
        else
        begin
            if (cmd.sum_clr)
            begin
                sum_reg   <= {{(SUM_W - BYTE_W){1'b0}}, in_byte};
                taken_reg <= '0;
            end
            else if (cmd.sum_add)
            begin
                sum_reg <= sum_next;
            end
            if (cmd.wr_param)
            begin
                taken_reg <= taken_inc;
            end
            if (cmd.ld_len_hi)
            begin
                length_reg <= {in_byte, BYTE_W'(0)};
            end
            if (cmd.ld_len_lo)
            begin
                length_reg <= {length_reg[LEN_W-1:BYTE_W], in_byte};
            end
            if (cmd.ld_cmd)
            begin
                command_reg <= in_byte;
            end
            if (cmd.ld_plen_hi)
            begin
                plen_hi_reg <= in_byte;
            end
            if (cmd.ld_plen_lo)
            begin
                expected_reg <= in_byte[COUNT_W-1:0];
            end
            if (cmd.ld_sum_hi)
            begin
                sum_hi_reg <= in_byte;
            end
            if (cmd.emit_clr)
            begin
                emit_reg <= '0;
            end
            else if (cmd.emit_ld)
            begin
                emit_reg <= emit_inc;
            end
        end
    end

    sfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PARAM_DEPTH)
    ) u_param_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_param),
        .wr_addr (taken_reg[AW-1:0]),
        .wr_data (in_byte),
        .rd_en   (cmd.emit_rd),
        .rd_addr (emit_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_ld)
        begin
            out_cmd_reg   <= command_reg;
            out_len_reg   <= length_reg;
            out_count_reg <= expected_reg;
            out_index_reg <= emit_reg[INDEX_W-1:0];
            out_byte_reg  <= ram_rd_data;
            out_last_reg  <= sts.emit_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_last  = out_last_reg;
    assign m_data  = {3'b000, out_byte_reg, out_index_reg, out_count_reg,
                      out_len_reg, out_cmd_reg};

    always_comb
    begin
        sts.hdr_ok      = (in_byte == header_reg);
        sts.ver_ok      = (in_byte == version_reg);
        sts.type_ok     = (in_byte == type_reg);
        sts.plen_ok     = (plen_hi_reg == '0) && (in_byte != '0)
                          && ({1'b0, in_byte} <= {{(BYTE_W + 1 - COUNT_W){1'b0}}, DEPTH_C});
        sts.params_done = (taken_inc == expected_reg);
        sts.sum_ok      = ({sum_hi_reg, in_byte} == sum_reg);
        sts.emit_last   = (emit_inc == expected_reg);
        sts.out_busy    = out_valid_reg;
    end

    // a parameter write stays inside the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_param |-> (taken_reg < DEPTH_C))
    else $error("parameter write beyond buffer depth");

    // the run closes on the entry whose index is count minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg)
            |-> ({1'b0, out_index_reg} + COUNT_W'(1) == out_count_reg))
    else $error("last flag on wrong parameter index");

endmodule

`default_nettype wire

// ===== sv/sfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfp_ctrl: frame parser controller
// Walks the frame fields byte by byte and sequences the parameter read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sfp_pkg::sfp_sts_t sts,
    output sfp_pkg::sfp_cmd_t      cmd
);

    import sfp_pkg::*;

    localparam logic [3:0] ST_HUNT    = 4'd0;
    localparam logic [3:0] ST_LEN_HI  = 4'd1;
    localparam logic [3:0] ST_LEN_LO  = 4'd2;
    localparam logic [3:0] ST_VER     = 4'd3;
    localparam logic [3:0] ST_TYPE    = 4'd4;
    localparam logic [3:0] ST_CMD     = 4'd5;
    localparam logic [3:0] ST_PLEN_HI = 4'd6;
    localparam logic [3:0] ST_PLEN_LO = 4'd7;
    localparam logic [3:0] ST_PARAM   = 4'd8;
    localparam logic [3:0] ST_SUM_HI  = 4'd9;
    localparam logic [3:0] ST_SUM_LO  = 4'd10;
    localparam logic [3:0] ST_EMIT_RD = 4'd11;
    localparam logic [3:0] ST_EMIT_LD = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       fire;

    assign in_ready = (state_reg != ST_EMIT_RD) && (state_reg != ST_EMIT_LD);
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_HUNT:
            begin
                cmd.sum_clr = fire;
                if (fire)
                begin
                    state_next = sts.hdr_ok ? ST_LEN_HI : ST_HUNT;
                end
            end
            ST_LEN_HI:
            begin
                cmd.ld_len_hi = fire;
                cmd.sum_add   = fire;
                if (fire)
                begin
                    state_next = ST_LEN_LO;
                end
            end
            ST_LEN_LO:
            begin
                cmd.ld_len_lo = fire;
                cmd.sum_add   = fire;
                if (fire)
                begin
                    state_next = ST_VER;
                end
            end
            ST_VER:
            begin
                cmd.sum_add = fire;
                if (fire)
                begin
                    state_next = sts.ver_ok ? ST_TYPE : ST_HUNT;
                end
            end
            ST_TYPE:
            begin
                cmd.sum_add = fire;
                if (fire)
                begin
                    state_next = sts.type_ok ? ST_CMD : ST_HUNT;
                end
            end
            ST_CMD:
            begin
                cmd.ld_cmd  = fire;
                cmd.sum_add = fire;
                if (fire)
                begin
                    state_next = ST_PLEN_HI;
                end
            end
            ST_PLEN_HI:
            begin
                cmd.ld_plen_hi = fire;
                cmd.sum_add    = fire;
                if (fire)
                begin
                    state_next = ST_PLEN_LO;
                end
            end
            ST_PLEN_LO:
            begin
                cmd.ld_plen_lo = fire;
                cmd.sum_add    = fire;
                if (fire)
                begin
                    state_next = sts.plen_ok ? ST_PARAM : ST_HUNT;
                end
            end
            ST_PARAM:
            begin
                cmd.wr_param = fire;
                cmd.sum_add  = fire;
                if (fire && sts.params_done)
                begin
                    state_next = ST_SUM_HI;
                end
            end
            ST_SUM_HI:
            begin
                cmd.ld_sum_hi = fire;
                if (fire)
                begin
                    state_next = ST_SUM_LO;
                end
            end
            ST_SUM_LO:
            begin
                cmd.emit_clr = fire;
                if (fire)
                begin
                    state_next = sts.sum_ok ? ST_EMIT_RD : ST_HUNT;
                end
            end
            ST_EMIT_RD:
            begin
                // wait for the output register to drain before the next read
                if (!sts.out_busy)
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                cmd.emit_ld = 1'b1;
                state_next  = sts.emit_last ? ST_HUNT : ST_EMIT_RD;
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a result is only loaded into an empty output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_ld |-> !sts.out_busy)
    else $error("output register overwritten");

    // a good checksum starts the read-out
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM_LO && fire && sts.sum_ok) |=> (state_reg == ST_EMIT_RD))
    else $error("read-out not started after good checksum");

    // every read is followed by a load in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_rd |=> cmd.emit_ld)
    else $error("parameter read not loaded");

endmodule

`default_nettype wire

// ===== sv/sensor_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_parser_unit: serial frame parser with 16-bit sum checksum
// input: one received byte per cycle while a frame is parsed; after the
//   checksum byte transfer, the first result follows a RAM read and a load
// read-out: each result takes a RAM read, an output load and a transfer in
//   turn; the input side stalls while a frame's parameters are sent
// reset: rst_n clears the parser to the header hunt and restores the default
//   register values at once; the parameter RAM has no reset
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_parser_unit #(
    parameter int PARAM_DEPTH = sfp_pkg::PARAM_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [sfp_pkg::BYTE_W-1:0]    s_axis_tdata,  // [7:0] in_byte
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [7:0] command_word, [23:8] frame_length, [30:24] param_count,
    // [36:31] param_index, [44:37] param_byte, [47:45] zero
    output logic [sfp_pkg::OUT_W-1:0]          m_axis_tdata,
    output logic                               m_axis_tlast,  // last
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sfp_pkg::BYTE_W-1:0]    cfg_data
);

    import sfp_pkg::*;

    sfp_cmd_t cmd;
    sfp_sts_t sts;

    assign cfg_ready = 1'b1;

    sfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfp_datapath #(
        .PARAM_DEPTH (PARAM_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_byte   (s_axis_tdata),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_last    (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sensor_frame_parser_unit
// Streams byte frames (good, corrupted, truncated, noise) into the parser and
// checks every parameter transfer against an in-bench model of the frame
// hunter, under random sender gaps, receiver stalls and register settings.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import sfp_pkg::*;

    localparam int DEPTH        = PARAM_DEPTH_DEF;
    localparam int RANDOM_BYTES = 60;
    localparam int SETTLE       = 8;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int HOLD_CYCLES  = 400;

    typedef enum logic [3:0] {
        PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_VERSION, PH_TYPE, PH_COMMAND,
        PH_PLEN_HI, PH_PLEN_LO, PH_PARAMS, PH_SUM_HI, PH_SUM_LO
    } parse_phase_e;

    typedef enum {
        FR_GOOD, FR_BAD_SUM, FR_SUM_ONES, FR_BAD_VERSION, FR_BAD_TYPE,
        FR_BAD_PLEN, FR_TRUNCATED
    } frame_flaw_e;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} param_fill_e;
    typedef enum {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_e;

    typedef struct packed {
        logic [7:0]  command_word;
        logic [15:0] frame_length;
        logic [6:0]  param_count;
        logic [5:0]  param_index;
        logic [7:0]  param_byte;
        logic        last;
    } param_result_t;

    typedef logic [7:0] byte_q_t [$];

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    sensor_frame_parser_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // parser model state
    logic [7:0]    hdr_reg, ver_reg, typ_reg;
    parse_phase_e  phase;
    logic [15:0]   run_sum;
    logic [6:0]    taken;
    logic [15:0]   want_params;
    logic [7:0]    cmd_hold;
    logic [15:0]   len_hold;
    logic [7:0]    sum_hi;
    logic [7:0]    param_mem [DEPTH];
    param_result_t param_results_q [$];

    // register values as last written by the stimulus
    logic [7:0] stim_hdr, stim_ver, stim_typ;

    int mismatch_count  = 0;
    int results_checked = 0;
    int frames_passed   = 0;
    int bytes_sent      = 0;
    int reg_writes      = 0;
    int burst_left      = 0;
    int hold_off_gen    = 0;
    int hold_off_len    = 0;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #4ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [15:0] mod_sum_add(input logic [15:0] acc, input logic [7:0] b);
        logic [16:0] s;
        s = {1'b0, acc} + {9'd0, b};
        return (s >= {1'b0, SUM_MOD}) ? 16'(s - {1'b0, SUM_MOD}) : s[15:0];
    endfunction

    function automatic void reset_model();
        hdr_reg     = HEADER_RST;
        ver_reg     = VERSION_RST;
        typ_reg     = TYPE_RST;
        phase       = PH_HUNT;
        run_sum     = '0;
        taken       = '0;
        want_params = '0;
        cmd_hold    = '0;
        len_hold    = '0;
        sum_hi      = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        case (idx)
            REG_HEADER:  hdr_reg = val;
            REG_VERSION: ver_reg = val;
            REG_TYPE:    typ_reg = val;
            default: ;
        endcase
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        param_result_t r;
        case (phase)
            PH_LEN_HI:
            begin
                len_hold = {b, 8'h00};
                phase    = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_hold[7:0] = b;
                phase         = PH_VERSION;
            end
            PH_VERSION: phase = (b == ver_reg) ? PH_TYPE : PH_HUNT;
            PH_TYPE:    phase = (b == typ_reg) ? PH_COMMAND : PH_HUNT;
            PH_COMMAND:
            begin
                cmd_hold = b;
                phase    = PH_PLEN_HI;
            end
            PH_PLEN_HI:
            begin
                want_params = {b, 8'h00};
                phase       = PH_PLEN_LO;
            end
            PH_PLEN_LO:
            begin
                want_params[7:0] = b;
                phase = (want_params != 0 && want_params <= DEPTH) ? PH_PARAMS : PH_HUNT;
            end
            PH_PARAMS:
            begin
                if (taken < DEPTH)
                    param_mem[taken[5:0]] = b;
                taken = taken + 7'd1;
                if ({9'd0, taken} == want_params)
                    phase = PH_SUM_HI;
            end
            PH_SUM_HI:
            begin
                sum_hi = b;
                phase  = PH_SUM_LO;
            end
            PH_SUM_LO:
            begin
                if ({sum_hi, b} == run_sum)
                begin
                    for (int k = 0; k < want_params && k < DEPTH; k++)
                    begin
                        r.command_word = cmd_hold;
                        r.frame_length = len_hold;
                        r.param_count  = want_params[6:0];
                        r.param_index  = 6'(k);
                        r.param_byte   = param_mem[6'(k)];
                        r.last         = (k + 1 == want_params);
                        param_results_q.push_back(r);
                    end
                    frames_passed++;
                end
                phase = PH_HUNT;
            end
            default:
            begin
                run_sum = '0;
                taken   = '0;
                phase   = (b == hdr_reg) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
        if (phase < PH_SUM_LO)
            run_sum = mod_sum_add(run_sum, b);
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, actual %0h", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        param_result_t want;
        if (param_results_q.size() == 0)
        begin
            $error("result with no frame pending: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
            mismatch_count++;
        end
        else
        begin
            want = param_results_q.pop_front();
            check_field("command_word", 16'(want.command_word), 16'(m_axis_tdata[7:0]));
            check_field("frame_length", want.frame_length,      m_axis_tdata[23:8]);
            check_field("param_count",  16'(want.param_count),  16'(m_axis_tdata[30:24]));
            check_field("param_index",  16'(want.param_index),  16'(m_axis_tdata[36:31]));
            check_field("param_byte",   16'(want.param_byte),   16'(m_axis_tdata[44:37]));
            check_field("tdata pad",    16'd0,                  16'(m_axis_tdata[47:45]));
            check_field("last",         16'(want.last),         16'(m_axis_tlast));
            results_checked++;
        end
    endtask

    // all sampling happens on pre-edge values
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
        end
    end

    // receiver: random stretches of open, choppy and slow acceptance plus requested hold-offs
    initial
    begin
        int       stretch_left;
        int       stall_left;
        int       seen_gen;
        rx_mode_e rx_mode;
        stretch_left = 0;
        stall_left   = 0;
        seen_gen     = 0;
        rx_mode      = RX_OPEN;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_gen != seen_gen)
            begin
                seen_gen   = hold_off_gen;
                stall_left = hold_off_len;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       rx_mode = RX_OPEN;
                        1:       rx_mode = RX_CHOPPY;
                        default: rx_mode = RX_SLOW;
                    endcase
                    stretch_left = $urandom_range(10, 80);
                end
                stretch_left--;
                case (rx_mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
                    default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_bytes(input byte_q_t q);
        foreach (q[i])
            send_byte(q[i]);
    endtask

    // wait until every predicted transfer is out and the parser has settled
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (param_results_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        wait_drained();
        case (idx)
            REG_HEADER:  stim_hdr = val;
            REG_VERSION: stim_ver = val;
            REG_TYPE:    stim_typ = val;
            default: ;
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge clk);
    endtask

    function automatic void build_frame(input logic [7:0] cmd, input logic [15:0] flen,
                                        input logic [15:0] plen, input frame_flaw_e flaw,
                                        input param_fill_e fill, output byte_q_t q);
        int          n_params;
        logic [15:0] chk;
        q = {};
        q.push_back(stim_hdr);
        q.push_back(flen[15:8]);
        q.push_back(flen[7:0]);
        q.push_back((flaw == FR_BAD_VERSION) ? stim_ver ^ 8'($urandom_range(1, 255)) : stim_ver);
        q.push_back((flaw == FR_BAD_TYPE) ? stim_typ ^ 8'($urandom_range(1, 255)) : stim_typ);
        q.push_back(cmd);
        q.push_back(plen[15:8]);
        q.push_back(plen[7:0]);
        n_params = (flaw == FR_BAD_PLEN) ? $urandom_range(0, 4) : int'(plen);
        for (int i = 0; i < n_params; i++)
        begin
            case (fill)
                FILL_ZERO: q.push_back(8'h00);
                FILL_ONES: q.push_back(8'hFF);
                default:   q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        chk = '0;
        foreach (q[i])
            chk = mod_sum_add(chk, q[i]);
        case (flaw)
            FR_BAD_SUM:  chk = chk ^ 16'($urandom_range(1, 65535));
            FR_SUM_ONES: chk = 16'hFFFF;
            default: ;
        endcase
        q.push_back(chk[15:8]);
        q.push_back(chk[7:0]);
        if (flaw == FR_TRUNCATED)
            repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
    endfunction

    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] flen,
                              input logic [15:0] plen, input frame_flaw_e flaw,
                              input param_fill_e fill);
        byte_q_t q;
        build_frame(cmd, flen, plen, flaw, fill, q);
        send_bytes(q);
    endtask

    // mostly short frames, now and then a long or full one
    function automatic logic [15:0] rand_plen();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            return 16'($urandom_range(1, 8));
        else if (pick < 95)
            return 16'($urandom_range(9, DEPTH - 1));
        else
            return 16'(DEPTH);
    endfunction

    function automatic logic [15:0] bad_plen();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'(DEPTH + 1);
            2:       return {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
            default: return 16'($urandom_range(DEPTH + 1, 255));
        endcase
    endfunction

    task automatic test_reset_values();
        send_frame(8'h5A, 16'd12, 16'd4, FR_GOOD, FILL_RANDOM);
    endtask

    task automatic test_field_extremes();
        send_frame(8'h00, 16'h0000, 16'd1, FR_GOOD, FILL_ZERO);
        send_frame(8'hFF, 16'hFFFF, 16'd2, FR_GOOD, FILL_ONES);
    endtask

    task automatic test_bad_frames();
        send_frame(8'h11, 16'd9, 16'd2, FR_BAD_VERSION, FILL_RANDOM);
        send_frame(8'h22, 16'd9, 16'd2, FR_BAD_TYPE, FILL_RANDOM);
        send_frame(8'h33, 16'd9, 16'd0, FR_BAD_PLEN, FILL_RANDOM);
        send_frame(8'h44, 16'd9, 16'(DEPTH + 1), FR_BAD_PLEN, FILL_RANDOM);
        send_frame(8'h55, 16'd9, 16'h0101, FR_BAD_PLEN, FILL_RANDOM);
        send_frame(8'h66, 16'd9, 16'd3, FR_BAD_SUM, FILL_RANDOM);
        // a sum of all ones can never match
        send_frame(8'h77, 16'd9, 16'd3, FR_SUM_ONES, FILL_RANDOM);
        send_frame(8'h88, 16'd9, 16'd3, FR_GOOD, FILL_RANDOM);
    endtask

    // a rejected byte is not reconsidered; the byte after it is the next header candidate
    task automatic test_resync();
        byte_q_t q;
        q = {stim_hdr, 8'h00, 8'h05, stim_ver ^ 8'h80};
        send_bytes(q);
        send_frame(8'h99, 16'd5, 16'd2, FR_GOOD, FILL_RANDOM);
        q = {stim_hdr, 8'h00, 8'h05, stim_hdr};
        send_bytes(q);
        build_frame(8'hAB, 16'd5, 16'd2, FR_GOOD, FILL_RANDOM, q);
        void'(q.pop_front());
        send_bytes(q);
        send_frame(8'hAC, 16'd5, 16'd1, FR_GOOD, FILL_RANDOM);
    endtask

    task automatic test_register_writes();
        byte_q_t     q;
        logic [7:0]  next_ver;
        write_reg(REG_HEADER, 8'h00);
        write_reg(REG_VERSION, 8'h00);
        write_reg(REG_TYPE, 8'h00);
        send_frame(8'h01, 16'd3, 16'd2, FR_GOOD, FILL_RANDOM);
        send_frame(8'h02, 16'd3, 16'd2, FR_BAD_TYPE, FILL_RANDOM);
        write_reg(REG_HEADER, 8'hFF);
        write_reg(REG_VERSION, 8'hFF);
        write_reg(REG_TYPE, 8'hFF);
        send_frame(8'h03, 16'd3, 16'd3, FR_GOOD, FILL_RANDOM);
        write_reg(REG_HEADER, 8'($urandom_range(0, 255)));
        write_reg(REG_VERSION, 8'($urandom_range(0, 255)));
        write_reg(REG_TYPE, 8'($urandom_range(0, 255)));
        send_frame(8'h04, 16'd3, 16'd2, FR_GOOD, FILL_RANDOM);
        // version changed between header and version byte
        next_ver = stim_ver ^ 8'h5C;
        write_reg(REG_VERSION, stim_ver);
        stim_ver = next_ver;
        build_frame(8'h05, 16'd3, 16'd2, FR_GOOD, FILL_RANDOM, q);
        send_bytes(q[0:2]);
        write_reg(REG_VERSION, next_ver);
        send_bytes(q[3:$]);
        write_reg(REG_HEADER, HEADER_RST);
        write_reg(REG_VERSION, VERSION_RST);
        write_reg(REG_TYPE, TYPE_RST);
    endtask

    // long receiver hold-off while full frames keep arriving, so the input side backs up
    task automatic test_output_stall();
        wait_drained();
        hold_off_len = HOLD_CYCLES;
        hold_off_gen++;
        send_frame(8'hC3, 16'd70, 16'(DEPTH), FR_GOOD, FILL_RANDOM);
        send_frame(8'h3C, 16'd70, 16'(DEPTH), FR_GOOD, FILL_RANDOM);
        send_frame(8'hE7, 16'd6, 16'd2, FR_GOOD, FILL_RANDOM);
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        int pick;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_frame(8'($urandom), 16'($urandom), rand_plen(), FR_GOOD, FILL_RANDOM);
            else if (pick < 67)
                send_frame(8'($urandom), 16'($urandom), rand_plen(), FR_BAD_SUM, FILL_RANDOM);
            else if (pick < 71)
                send_frame(8'($urandom), 16'($urandom), rand_plen(), FR_BAD_VERSION,
                           FILL_RANDOM);
            else if (pick < 75)
                send_frame(8'($urandom), 16'($urandom), rand_plen(), FR_BAD_TYPE, FILL_RANDOM);
            else if (pick < 79)
                send_frame(8'($urandom), 16'($urandom), bad_plen(), FR_BAD_PLEN, FILL_RANDOM);
            else if (pick < 85)
                send_frame(8'($urandom), 16'($urandom), rand_plen(), FR_TRUNCATED, FILL_RANDOM);
            else if (pick < 96)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            else
            begin
                case ($urandom_range(0, 2))
                    0:       write_reg(REG_HEADER, 8'($urandom_range(0, 255)));
                    1:       write_reg(REG_VERSION, 8'($urandom_range(0, 255)));
                    default: write_reg(REG_TYPE, 8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    task automatic finish_run();
        wait_drained();
        if (param_results_q.size() != 0)
        begin
            $error("%0d parameter transfers never arrived", param_results_q.size());
            mismatch_count += param_results_q.size();
        end
        $display("covered %0d input bytes, %0d frames passed, %0d parameter transfers checked",
                 bytes_sent, frames_passed, results_checked);
        $display("%0d register writes, one %0d-cycle output hold-off, %0d mismatches",
                 reg_writes, HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    endtask

    initial
    begin
        reset_model();
        stim_hdr = HEADER_RST;
        stim_ver = VERSION_RST;
        stim_typ = TYPE_RST;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_HEADER;
        cfg_data      <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_field_extremes();
        test_bad_frames();
        test_resync();
        test_register_writes();
        test_output_stall();
        test_random_traffic();
        finish_run();
    end

endmodule
